// ----- src/llb_pkg.sv -----
package llb_pkg;

   // default sizes
   localparam int SAMPLE_BITS_DEF   = 10;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int SEGMENTS_DEF      = 5;

   // fixed field widths
   localparam int COEFF_BITS      = 16;
   localparam int POINT_BITS      = 10;
   localparam int POINT_COUNT     = 4;
   localparam int LEVEL_BITS      = 8;
   localparam int LEVEL_COUNT     = 6;
   localparam int OVERRIDE_BITS   = 9;
   localparam int BREAKPOINT_BITS = POINT_BITS * POINT_COUNT;
   localparam int LEVELS_BITS     = LEVEL_BITS * LEVEL_COUNT;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = LEVELS_BITS;

   localparam logic [OVERRIDE_BITS-1:0] OVERRIDE_LIMIT = 9'd256;

   // register reset values
   localparam logic [COEFF_BITS-1:0]      COEFF_RESET       = 16'd655;
   localparam logic [BREAKPOINT_BITS-1:0] BREAKPOINTS_RESET = 40'd967207199020;
   localparam logic [LEVELS_BITS-1:0]     LEVELS_RESET      = 48'd16557640016032;
   localparam logic [OVERRIDE_BITS-1:0]   OVERRIDE_RESET    = 9'd256;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEFF       = 2'd0,
      CSR_BREAKPOINTS = 2'd1,
      CSR_LEVELS      = 2'd2,
      CSR_OVERRIDE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BREAKPOINT_BITS-1:0] breakpoints;
      logic [LEVELS_BITS-1:0]     levels;
   } curve_cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } curve_status_type;

endpackage

// ----- src/llb_curve.sv -----
module llb_curve #(
   parameter int SAMPLE_BITS = llb_pkg::SAMPLE_BITS_DEF,
   parameter int SEGMENTS    = llb_pkg::SEGMENTS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [SAMPLE_BITS-1:0]              level,
   input  llb_pkg::curve_cfg_type              cfg,
   output llb_pkg::curve_status_type           status,
   output logic [llb_pkg::LEVEL_BITS-1:0]      value
);
   import llb_pkg::*;

   localparam int XW     = (SAMPLE_BITS > POINT_BITS) ? SAMPLE_BITS : POINT_BITS;
   localparam int NW     = XW + LEVEL_BITS;
   localparam int STEP_W = $clog2(LEVEL_BITS);
   localparam logic [XW-1:0]     FULL_SCALE = XW'((1 << SAMPLE_BITS) - 1);
   localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(LEVEL_BITS - 1);

   typedef enum logic [5:0] {
      C_IDLE   = 6'b000001,
      C_MUL    = 6'b000010,
      C_BIAS   = 6'b000100,
      C_DIV    = 6'b001000,
      C_FINISH = 6'b010000,
      C_DONE   = 6'b100000
   } c_state_type;

   c_state_type state_ff, state_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [XW-1:0]         dl_ff, dl_in;
   logic [XW-1:0]         dx_ff, dx_in;
   logic [LEVEL_BITS-1:0] y1_ff, y1_in;
   logic [LEVEL_BITS-1:0] dy_ff, dy_in;
   logic                  desc_ff, desc_in;
   logic [NW-1:0]         prod_ff, prod_in;
   logic [XW-1:0]         rem_ff, rem_in;
   logic [LEVEL_BITS-1:0] quo_ff, quo_in;
   logic [LEVEL_BITS-1:0] value_ff, value_in;

   logic [XW-1:0]         px [0:SEGMENTS];
   logic [LEVEL_BITS-1:0] py [0:SEGMENTS];
   logic [XW-1:0]         level_x;
   logic [XW-1:0]         sel_x1, sel_x2;
   logic [LEVEL_BITS-1:0] sel_y1, sel_y2, fixed_y;
   logic                  hit, full, fixed;
   logic [NW-1:0]         bias_n;
   logic [XW:0]           trial, trial_sub;
   logic                  trial_ge;

   assign level_x = XW'(level);

   // curve points: zero, inner breakpoints, full scale
   always_comb begin
      px[0]        = '0;
      px[SEGMENTS] = FULL_SCALE;
      for (int k = 1; k < SEGMENTS; k++) begin
         px[k] = XW'(cfg.breakpoints[(k-1)*POINT_BITS +: POINT_BITS]);
      end
      for (int k = 0; k <= SEGMENTS; k++) begin
         py[k] = cfg.levels[k*LEVEL_BITS +: LEVEL_BITS];
      end
   end

   // lowest matching segment wins, empty segments never match
   always_comb begin
      hit    = 1'b0;
      sel_x1 = '0;
      sel_x2 = '0;
      sel_y1 = '0;
      sel_y2 = '0;
      for (int k = SEGMENTS - 1; k >= 0; k--) begin
         if (level_x >= px[k] && level_x < px[k+1]) begin
            hit    = 1'b1;
            sel_x1 = px[k];
            sel_x2 = px[k+1];
            sel_y1 = py[k];
            sel_y2 = py[k+1];
         end
      end
   end

   assign full    = level_x >= FULL_SCALE;
   assign fixed   = full || !hit;
   assign fixed_y = full ? py[SEGMENTS] : '0;

   assign bias_n    = prod_ff + (desc_ff ? NW'(dx_ff - XW'(1)) : '0);
   assign trial     = {rem_ff, quo_ff[LEVEL_BITS-1]};
   assign trial_sub = trial - {1'b0, dx_ff};
   assign trial_ge  = trial >= {1'b0, dx_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dl_in    = dl_ff;
      dx_in    = dx_ff;
      y1_in    = y1_ff;
      dy_in    = dy_ff;
      desc_in  = desc_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      value_in = value_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               dl_in    = level_x - sel_x1;
               dx_in    = sel_x2 - sel_x1;
               y1_in    = fixed ? fixed_y : sel_y1;
               desc_in  = !fixed && (sel_y2 < sel_y1);
               dy_in    = (sel_y2 < sel_y1) ? sel_y1 - sel_y2 : sel_y2 - sel_y1;
               prod_in  = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = fixed ? C_FINISH : C_MUL;
            end
         end
         C_MUL: begin
            // one bit of the level step a cycle, top bit first
            prod_in = {prod_ff[NW-2:0], 1'b0} + (dy_ff[LEVEL_BITS-1] ? NW'(dl_ff) : '0);
            dy_in   = dy_ff << 1;
            cnt_in  = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_LAST) begin
               state_in = C_BIAS;
            end
         end
         C_BIAS: begin
            // descending segments round the step up
            rem_in   = bias_n[NW-1:LEVEL_BITS];
            quo_in   = bias_n[LEVEL_BITS-1:0];
            cnt_in   = '0;
            state_in = C_DIV;
         end
         C_DIV: begin
            // restoring divide, one quotient bit a cycle
            rem_in = trial_ge ? trial_sub[XW-1:0] : trial[XW-1:0];
            quo_in = {quo_ff[LEVEL_BITS-2:0], trial_ge};
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_LAST) begin
               state_in = C_FINISH;
            end
         end
         C_FINISH: begin
            value_in = desc_ff ? y1_ff - quo_ff : y1_ff + quo_ff;
            state_in = C_DONE;
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff    <= dl_in;
      dx_ff    <= dx_in;
      y1_ff    <= y1_in;
      dy_ff    <= dy_in;
      desc_ff  <= desc_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      value_ff <= value_in;
   end

   assign status.busy = state_ff != C_IDLE;
   assign status.done = state_ff == C_DONE;
   assign value       = value_ff;

endmodule

// ----- src/light_level_to_brightness_top.sv -----
// the average multiply and add run first, then the curve; the first sample after
// reset loads the average as is, and the curve skips its multiply and divide when the
// level is full scale or hits no segment; no new sample is taken until the result is
// loaded, with the bit-serial 16-step average multiply and 8-step curve multiply and divide
// reset: synchronous, active high; clears the average and the primed flag and
// loads the register defaults (coefficient 655, curve points, no override)
module light_level_to_brightness_top #(
   parameter int SAMPLE_BITS   = llb_pkg::SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = llb_pkg::FRACTION_BITS_DEF,
   parameter int SEGMENTS      = llb_pkg::SEGMENTS_DEF,
   localparam int REQ_W = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((llb_pkg::LEVEL_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // sample input channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_W-1:0]                    req_tdata,   // adc_sample, zero pad
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_W-1:0]                    rsp_tdata,   // brightness, filtered_level, zero pad
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [llb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [llb_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import llb_pkg::*;

   localparam int AW        = SAMPLE_BITS + FRACTION_BITS;
   localparam int MUL_CNT_W = $clog2(COEFF_BITS);
   localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(COEFF_BITS - 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MUL   = 6'b000010,
      S_ADD   = 6'b000100,
      S_START = 6'b001000,
      S_CURVE = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [COEFF_BITS-1:0]      coeff_ff, coeff_in;
   logic [BREAKPOINT_BITS-1:0] breakpoints_ff, breakpoints_in;
   logic [LEVELS_BITS-1:0]     levels_ff, levels_in;
   logic [OVERRIDE_BITS-1:0]   override_ff, override_in;

   // moving average state, unsigned fixed point
   logic [AW-1:0]              avg_ff, avg_in;
   logic                       primed_ff, primed_in;

   // bit-serial multiply of coefficient by signed difference
   logic [AW:0]                diff_ff, diff_in;
   logic [AW:0]                acc_ff, acc_in;
   logic                       lsb_ff, lsb_in;
   logic [COEFF_BITS-1:0]      coeff_sr_ff, coeff_sr_in;
   logic [MUL_CNT_W-1:0]       mul_cnt_ff, mul_cnt_in;
   logic [AW+1:0]              mul_sum;

   // result output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]      rsp_bright_ff, rsp_bright_in;
   logic [SAMPLE_BITS-1:0]     rsp_level_ff, rsp_level_in;

   logic                       req_accept, csr_accept, rsp_free, rsp_load;
   logic [SAMPLE_BITS-1:0]     sample, level;
   logic [AW-1:0]              target;
   logic [LEVEL_BITS-1:0]      bright, curve_value;
   logic                       curve_start;
   curve_cfg_type              curve_cfg;
   curve_status_type           curve_status;

   assign req_tready = state_ff == S_IDLE;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   assign sample  = req_tdata[SAMPLE_BITS-1:0];
   assign target  = {sample, {FRACTION_BITS{1'b0}}};
   assign level   = avg_ff[AW-1 -: SAMPLE_BITS];

   // accumulate, then shift one bit out; the last bit out is the rounding bit
   assign mul_sum = {acc_ff[AW], acc_ff} + (coeff_sr_ff[0] ? {diff_ff[AW], diff_ff} : '0);

   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign curve_start = state_ff == S_START;
   assign bright      = (override_ff < OVERRIDE_LIMIT) ? override_ff[LEVEL_BITS-1:0]
                                                       : curve_value;

   assign curve_cfg.breakpoints = breakpoints_ff;
   assign curve_cfg.levels      = levels_ff;

   llb_curve #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SEGMENTS    (SEGMENTS)
   ) u_curve (
      .clock  (clock),
      .reset  (reset),
      .start  (curve_start),
      .level  (level),
      .cfg    (curve_cfg),
      .status (curve_status),
      .value  (curve_value)
   );

   // register writes, only while no sample is in flight: the user must keep to this, the block does not enforce it
   always_comb begin
      coeff_in       = coeff_ff;
      breakpoints_in = breakpoints_ff;
      levels_in      = levels_ff;
      override_in    = override_ff;
      if (csr_accept) begin
         unique case (csr_index_type'(csr_index))
            CSR_COEFF:       coeff_in       = csr_data[COEFF_BITS-1:0];
            CSR_BREAKPOINTS: breakpoints_in = csr_data[BREAKPOINT_BITS-1:0];
            CSR_LEVELS:      levels_in      = csr_data[LEVELS_BITS-1:0];
            CSR_OVERRIDE:    override_in    = csr_data[OVERRIDE_BITS-1:0];
            default:         coeff_in       = coeff_ff;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      avg_in      = avg_ff;
      primed_in   = primed_ff;
      diff_in     = diff_ff;
      acc_in      = acc_ff;
      lsb_in      = lsb_ff;
      coeff_sr_in = coeff_sr_ff;
      mul_cnt_in  = mul_cnt_ff;
      rsp_load    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (primed_ff) begin
                  diff_in     = {1'b0, target} - {1'b0, avg_ff};
                  acc_in      = '0;
                  lsb_in      = 1'b0;
                  coeff_sr_in = coeff_ff;
                  mul_cnt_in  = '0;
                  state_in    = S_MUL;
               end else begin
                  // first sample after reset loads the average as is
                  avg_in    = target;
                  primed_in = 1'b1;
                  state_in  = S_START;
               end
            end
         end
         S_MUL: begin
            acc_in      = mul_sum[AW+1:1];
            lsb_in      = mul_sum[0];
            coeff_sr_in = coeff_sr_ff >> 1;
            mul_cnt_in  = mul_cnt_ff + MUL_CNT_W'(1);
            if (mul_cnt_ff == MUL_LAST) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            // step is floor of product / 2^16 plus half-bit; never goes below zero
            avg_in   = avg_ff + acc_ff[AW-1:0] + AW'(lsb_ff);
            state_in = S_START;
         end
         S_START: begin
            state_in = S_CURVE;
         end
         S_CURVE: begin
            if (curve_status.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_bright_in = rsp_load ? bright : rsp_bright_ff;
   assign rsp_level_in  = rsp_load ? level : rsp_level_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         coeff_ff       <= COEFF_RESET;
         breakpoints_ff <= BREAKPOINTS_RESET;
         levels_ff      <= LEVELS_RESET;
         override_ff    <= OVERRIDE_RESET;
         avg_ff         <= '0;
         primed_ff      <= 1'b0;
         mul_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         coeff_ff       <= coeff_in;
         breakpoints_ff <= breakpoints_in;
         levels_ff      <= levels_in;
         override_ff    <= override_in;
         avg_ff         <= avg_in;
         primed_ff      <= primed_in;
         mul_cnt_ff     <= mul_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      acc_ff        <= acc_in;
      lsb_ff        <= lsb_in;
      coeff_sr_ff   <= coeff_sr_in;
      rsp_bright_ff <= rsp_bright_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_level_ff, rsp_bright_ff});

`ifndef ASSERT_OFF
   // curve unit is quiet whenever a new sample may be taken
   a_curve_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !curve_status.busy)
      else $error("curve unit busy while waiting for a sample");

   // curve completion only while the sequencer waits for it
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      curve_status.done |-> (state_ff == S_CURVE))
      else $error("curve finished outside its wait state");

   // a result appears only from the output step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output step");

   // any accepted sample leaves the average primed
   a_primed: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> primed_ff)
      else $error("average not primed after a sample");
`endif

endmodule

// ----- verif/tb_light_level_to_brightness_top.sv -----
module tb_light_level_to_brightness_top;
   import llb_pkg::*;

   localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
   localparam int FRACTION_BITS = FRACTION_BITS_DEF;
   localparam int SEGMENTS      = SEGMENTS_DEF;
   localparam int FULL_SCALE    = (1 << SAMPLE_BITS) - 1;
   localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;
   localparam int REQ_W         = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_W         = ((LEVEL_BITS + SAMPLE_BITS + 7) / 8) * 8;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 172;

   typedef struct {
      logic [LEVEL_BITS-1:0]  brightness;
      logic [SAMPLE_BITS-1:0] filtered_level;
   } brightness_result_type;

   // shapes of the random sample stream
   typedef enum int {RUN_STEADY, RUN_NOISE, RUN_RAIL, RUN_JITTER} sample_run_type;

   // tracks the smoothed level and the curve settings, keeps the results still due
   class brightness_scoreboard;
      logic [COEFF_BITS-1:0]      coeff;
      logic [BREAKPOINT_BITS-1:0] breakpoints;
      logic [LEVELS_BITS-1:0]     levels;
      logic [OVERRIDE_BITS-1:0]   override_value;
      logic [AVG_BITS-1:0]        average;
      bit                         primed;
      brightness_result_type      pending_brightness[$];
      int                         errors;

      function new();
         coeff          = COEFF_RESET;
         breakpoints    = BREAKPOINTS_RESET;
         levels         = LEVELS_RESET;
         override_value = OVERRIDE_RESET;
         average        = '0;
         primed         = 1'b0;
         errors         = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_COEFF:       coeff          = value[COEFF_BITS-1:0];
            CSR_BREAKPOINTS: breakpoints    = value[BREAKPOINT_BITS-1:0];
            CSR_LEVELS:      levels         = value[LEVELS_BITS-1:0];
            CSR_OVERRIDE:    override_value = value[OVERRIDE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned point_x(int k);
         if (k == 0)
            return 0;
         if (k >= SEGMENTS)
            return FULL_SCALE;
         return 32'(breakpoints[(k-1)*POINT_BITS +: POINT_BITS]);
      endfunction

      function int unsigned point_y(int k);
         return 32'(levels[k*LEVEL_BITS +: LEVEL_BITS]);
      endfunction

      // lowest matching segment wins, empty segments never match
      function logic [LEVEL_BITS-1:0] curve_brightness(int unsigned level);
         int unsigned x1, x2, y1, y2, dx, dl;
         if (level >= FULL_SCALE)
            return point_y(SEGMENTS);
         for (int k = 0; k < SEGMENTS; k++) begin
            x1 = point_x(k);
            x2 = point_x(k + 1);
            if (level >= x1 && level < x2) begin
               y1 = point_y(k);
               y2 = point_y(k + 1);
               dx = x2 - x1;
               dl = level - x1;
               if (y2 >= y1)
                  return LEVEL_BITS'(y1 + (dl * (y2 - y1)) / dx);
               return LEVEL_BITS'(y1 - (dl * (y1 - y2) + dx - 1) / dx);
            end
         end
         return '0;
      endfunction

      function void note_sample(logic [SAMPLE_BITS-1:0] sample);
         longint target, step, updated;
         brightness_result_type res;
         target = longint'(sample) << FRACTION_BITS;
         if (!primed) begin
            average = AVG_BITS'(target);
            primed  = 1'b1;
         end else begin
            // floor of the rounded step, so ties go towards plus infinity
            step = (longint'(coeff) * (target - longint'(average))
                    + (longint'(1) << (COEFF_BITS - 1))) >>> COEFF_BITS;
            updated = longint'(average) + step;
            if (updated < 0)
               updated = 0;
            average = AVG_BITS'(updated);
         end
         res.filtered_level = average[AVG_BITS-1:FRACTION_BITS];
         if (override_value < OVERRIDE_LIMIT)
            res.brightness = override_value[LEVEL_BITS-1:0];
         else
            res.brightness = curve_brightness(32'(res.filtered_level));
         pending_brightness.push_back(res);
      endfunction

      function void check_result(logic [LEVEL_BITS-1:0] brightness,
                                 logic [SAMPLE_BITS-1:0] filtered_level);
         brightness_result_type want;
         if (pending_brightness.size() == 0) begin
            $error("result with nothing due: brightness %0d, filtered_level %0d",
                   brightness, filtered_level);
            errors++;
            return;
         end
         want = pending_brightness.pop_front();
         if (brightness !== want.brightness) begin
            $error("brightness: expected %0d, actual %0d", want.brightness, brightness);
            errors++;
         end
         if (filtered_level !== want.filtered_level) begin
            $error("filtered_level: expected %0d, actual %0d",
                   want.filtered_level, filtered_level);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_brightness.size();
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // sample channel, adc_sample in bits 9..0
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_W-1:0]         req_tdata  = '0;
   // result channel, brightness in bits 7..0 and filtered_level in bits 17..8
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_W-1:0]         rsp_tdata;
   // register write channel
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // no idling on either side while set
   bit steady = 1'b0;

   brightness_scoreboard predictor = new();

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   light_level_to_brightness_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // result side: check each transfer, then pick the next ready with random stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         predictor.check_result(rsp_tdata[LEVEL_BITS-1:0],
                                rsp_tdata[LEVEL_BITS +: SAMPLE_BITS]);
      rsp_tready <= steady || ($urandom_range(0, 99) >= 9);
   end

   // one sample transfer, with random idle cycles ahead of it
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
      while (!steady && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(sample);
      do @(posedge clock); while (!req_tready);
      predictor.note_sample(sample);
   endtask

   // stop sending and let every due result arrive
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (predictor.outstanding() != 0);
   endtask

   task automatic write_register(input csr_index_type idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      predictor.write_register(idx, value);
   endtask

   // registers are only touched once the block has drained
   task automatic apply_setting(input logic [COEFF_BITS-1:0]      coeff,
                                input logic [BREAKPOINT_BITS-1:0] breakpoints,
                                input logic [LEVELS_BITS-1:0]     levels,
                                input logic [OVERRIDE_BITS-1:0]   override_value);
      wait_idle();
      write_register(CSR_COEFF, CSR_DATA_BITS'(coeff));
      write_register(CSR_BREAKPOINTS, CSR_DATA_BITS'(breakpoints));
      write_register(CSR_LEVELS, CSR_DATA_BITS'(levels));
      write_register(CSR_OVERRIDE, CSR_DATA_BITS'(override_value));
   endtask

   task automatic random_setting();
      logic [COEFF_BITS-1:0]      coeff;
      logic [BREAKPOINT_BITS-1:0] breakpoints;
      logic [LEVELS_BITS-1:0]     levels;
      logic [OVERRIDE_BITS-1:0]   override_value;
      int unsigned                x;
      case ($urandom_range(0, 5))
         0:       coeff = '0;
         1:       coeff = '1;
         2, 3:    coeff = COEFF_BITS'($urandom_range(1, 4095));
         default: coeff = COEFF_BITS'($urandom);
      endcase
      // mostly ascending points, empty segments now and then, sometimes anything
      if ($urandom_range(0, 4) == 0) begin
         breakpoints = BREAKPOINT_BITS'({$urandom, $urandom});
      end else begin
         x = 0;
         for (int k = 0; k < POINT_COUNT; k++) begin
            x = x + $urandom_range(0, 250);
            breakpoints[k*POINT_BITS +: POINT_BITS] = POINT_BITS'(x);
         end
      end
      levels = LEVELS_BITS'({$urandom, $urandom});
      if ($urandom_range(0, 9) < 7)
         override_value = OVERRIDE_BITS'(256 + $urandom_range(0, 255));
      else
         override_value = OVERRIDE_BITS'($urandom_range(0, 255));
      apply_setting(coeff, breakpoints, levels, override_value);
   endtask

   initial begin
      int unsigned      run_left, run_value, guard;
      sample_run_type   run_kind;
      logic [SAMPLE_BITS-1:0] sample;
      run_left  = 0;
      run_value = 0;
      run_kind  = RUN_STEADY;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: first sample loads the average, and lands on full scale
      send_sample(10'd1023);
      send_sample(10'd0);
      send_sample(10'd300);
      send_sample(10'd1000);

      // fastest filter, points out of order with empty segments, falling levels,
      // override just above the limit so the curve still applies
      apply_setting(16'hFFFF, {10'd1023, 10'd200, 10'd200, 10'd600},
                    {8'd7, 8'd90, 8'd0, 8'd200, 8'd255, 8'd10}, 9'd257);
      send_sample(10'd0);
      send_sample(10'd250);
      send_sample(10'd700);
      send_sample(10'd1023);
      send_sample(10'd1023);
      send_sample(10'd1023);
      send_sample(10'd1022);

      // all breakpoints at zero: forced brightness 0 and 255, then the curve with all levels at 255
      apply_setting(16'hFFFF, '0, '0, 9'd0);
      send_sample(10'd5);
      send_sample(10'd1023);
      apply_setting(16'hFFFF, '0, '0, 9'd255);
      send_sample(10'd0);
      apply_setting(16'hFFFF, '0, '1, 9'd511);
      send_sample(10'd512);

      // all points at full scale, everything below it is one wide segment
      apply_setting(16'hFFFF, '1, '1, 9'd256);
      send_sample(10'd100);
      send_sample(10'd1023);
      // frozen filter
      apply_setting(16'd0, '1, {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 9'd256);
      send_sample(10'd0);
      send_sample(10'd1023);

      for (int phase = 0; phase < PHASES; phase++) begin
         random_setting();
         steady = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off until the block has fully drained
            if (phase == 4 && n == 80)
               wait_idle();
            if (run_left == 0) begin
               run_left  = $urandom_range(1, 24);
               run_kind  = sample_run_type'($urandom_range(0, 3));
               run_value = $urandom_range(0, FULL_SCALE);
            end
            run_left--;
            case (run_kind)
               RUN_STEADY: sample = SAMPLE_BITS'(run_value);
               RUN_NOISE:  sample = SAMPLE_BITS'($urandom);
               RUN_RAIL:   sample = $urandom_range(0, 1) ? SAMPLE_BITS'(FULL_SCALE) : '0;
               default:    sample = SAMPLE_BITS'(run_value ^ $urandom_range(0, 31));
            endcase
            send_sample(sample);
         end
      end
      steady = 1'b0;

      // drain, bounded
      req_tvalid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (predictor.outstanding() != 0 && guard < 20000);
      if (predictor.outstanding() != 0) begin
         $error("%0d results never arrived", predictor.outstanding());
         predictor.errors++;
      end
      // catch any stray result after the last one due
      repeat (60) @(posedge clock);

      if (predictor.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- light_level_to_brightness_top.f -----
src/llb_pkg.sv
src/llb_curve.sv
src/light_level_to_brightness_top.sv
verif/tb_light_level_to_brightness_top.sv
